@@ rtl/prc_pkg.sv @@
// Shared types, constants and angle table for the polar rectification point map.
// No dependencies; used by every file under rtl/ except prc_mul48.sv.
package prc_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic signed [31:0] PI_Q20     = 32'sd3294199;
    localparam logic signed [31:0] TWO_PI_Q20 = 32'sd6588397;
    localparam logic [29:0]        KINV_Q30   = 30'd652032874;

    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_MODE_FLAGS = 3'd2,
        REG_RHO_MIN    = 3'd3,
        REG_RADIUS_MAX = 3'd4,
        REG_THETA_MIN  = 3'd5,
        REG_THETA_MAX  = 3'd6,
        REG_OUT_SIZE   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [47:0] point_x;
        logic signed [47:0] point_y;
    } t_point_in;

    typedef struct packed {
        logic signed [47:0] rect_x;
        logic signed [47:0] rect_y;
    } t_point_out;

    // data riding alongside the CORDIC chain
    typedef struct packed {
        logic               zero;
        logic signed [47:0] px;
        logic signed [47:0] py;
    } t_side;

    // atan(2^-i) in Q20
    function automatic logic signed [31:0] atan_q20(input int i);
        logic signed [31:0] r;
        r = 32'sd0;
        if (i == 0)      r = 32'sd823550;
        else if (i == 1) r = 32'sd486170;
        else if (i == 2) r = 32'sd256879;
        else if (i == 3) r = 32'sd130396;
        else if (i == 4) r = 32'sd65451;
        else if (i == 5) r = 32'sd32757;
        else if (i == 6) r = 32'sd16383;
        else if (i == 7) r = 32'sd8192;
        else if (i <= 20) r = 32'sd1 <<< (20 - i);
        return r;
    endfunction

endpackage

@@ rtl/prc_cordic_stage.sv @@
// One registered vectoring CORDIC iteration with fixed shift STEP.
// Depends on prc_pkg.
module prc_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [31:0] i_z,
    input  prc_pkg::t_side     i_side,
    output logic               o_valid,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [31:0] o_z,
    output prc_pkg::t_side     o_side
);

    localparam logic signed [31:0] ANG = prc_pkg::atan_q20(STEP);

    logic signed [63:0] xs, ys;
    logic               r_valid;
    logic signed [63:0] r_x, r_y;
    logic signed [31:0] r_z;
    prc_pkg::t_side     r_side;

    assign xs = i_x >>> STEP;
    assign ys = i_y >>> STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            if (i_y > 64'sd0) begin
                r_x <= i_x + ys;
                r_y <= i_y - xs;
                r_z <= i_z + ANG;
            end else begin
                r_x <= i_x - ys;
                r_y <= i_y + xs;
                r_z <= i_z - ANG;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

@@ rtl/prc_mul48.sv @@
// Two-stage signed 48x48 multiplier: 24-bit partial products, then their sum.
// No package dependency.
module prc_mul48 (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [47:0] i_a,
    input  logic signed [47:0] i_b,
    output logic signed [95:0] o_p
);

    logic signed [23:0] ah, bh;
    logic signed [24:0] al, bl;
    logic signed [47:0] r_hh;
    logic signed [48:0] r_hl, r_lh;
    logic signed [49:0] r_ll;
    logic signed [95:0] r_p;

    assign ah = i_a[47:24];
    assign bh = i_b[47:24];
    assign al = $signed({1'b0, i_a[23:0]});
    assign bl = $signed({1'b0, i_b[23:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= ah * bh;
            r_hl <= ah * bl;
            r_lh <= al * bh;
            r_ll <= al * bl;
            r_p  <= (96'(r_hh) <<< 48) + (96'(r_hl) <<< 24) + (96'(r_lh) <<< 24)
                    + 96'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/polar_rectify_point_map.sv @@
// Polar rectification point map: one point per clock while the output is not
// stalled, fully pipelined. Its length is set by the CORDIC chain (one register
// per iteration) plus input, pre-rotation, gain/wrap, multiply, rounding and
// output stages. The whole pipeline holds while a result is stalled at the
// output. Depends on prc_pkg, prc_cordic_stage and prc_mul48.
module polar_rectify_point_map #(
    parameter int CORDIC_STEPS = prc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  prc_pkg::t_point_in  i_point,
    output logic                o_valid,
    input  logic                i_stall,
    output prc_pkg::t_point_out o_rect,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [47:0]         i_cfg_data
);

    localparam logic signed [89:0] SAT_HI = 90'sd140737488355327;
    localparam logic signed [89:0] SAT_LO = -90'sd140737488355328;

    function automatic logic signed [47:0] sat48(input logic signed [89:0] v);
        logic signed [47:0] r;
        r = v[47:0];
        if (v > SAT_HI)      r = SAT_HI[47:0];
        else if (v < SAT_LO) r = SAT_LO[47:0];
        return r;
    endfunction

    // configuration
    logic signed [47:0] r_cx, r_cy, r_rmin;
    logic [1:0]         r_mode;
    logic [46:0]        r_rmax;
    logic signed [24:0] r_tmin, r_tmax;
    logic [31:0]        r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_mode <= '0;
            r_rmin <= '0;
            r_rmax <= '0;
            r_tmin <= '0;
            r_tmax <= '0;
            r_size <= '0;
        end else if (i_cfg_we) begin
            case (prc_pkg::t_reg_idx'(i_cfg_idx))
                prc_pkg::REG_CENTER_X:   r_cx   <= i_cfg_data;
                prc_pkg::REG_CENTER_Y:   r_cy   <= i_cfg_data;
                prc_pkg::REG_MODE_FLAGS: r_mode <= i_cfg_data[1:0];
                prc_pkg::REG_RHO_MIN:    r_rmin <= i_cfg_data;
                prc_pkg::REG_RADIUS_MAX: r_rmax <= i_cfg_data[46:0];
                prc_pkg::REG_THETA_MIN:  r_tmin <= i_cfg_data[24:0];
                prc_pkg::REG_THETA_MAX:  r_tmax <= i_cfg_data[24:0];
                prc_pkg::REG_OUT_SIZE:   r_size <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // stage A: differences to the center
    logic               r_a_valid;
    logic signed [47:0] r_a_px, r_a_py;
    logic signed [48:0] r_a_dx, r_a_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else if (en)  r_a_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_px <= i_point.point_x;
            r_a_py <= i_point.point_y;
            r_a_dx <= 49'(i_point.point_x) - 49'(r_cx);
            r_a_dy <= 49'(i_point.point_y) - 49'(r_cy);
        end
    end

    // stage B: scale to Q28 and fold into the right half plane
    logic signed [63:0] x0, y0;
    logic               r_b_valid;
    logic signed [63:0] r_b_x, r_b_y;
    logic signed [31:0] r_b_z;
    prc_pkg::t_side     r_b_side;

    assign x0 = 64'(r_a_dx) <<< 12;
    assign y0 = 64'(r_a_dy) <<< 12;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_valid <= 1'b0;
        else if (en)  r_b_valid <= r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side.zero <= (r_a_dx == 49'sd0) && (r_a_dy == 49'sd0);
            r_b_side.px   <= r_a_px;
            r_b_side.py   <= r_a_py;
            if (r_a_dx < 49'sd0) begin
                r_b_x <= -x0;
                r_b_y <= -y0;
                r_b_z <= (r_a_dy >= 49'sd0) ? prc_pkg::PI_Q20 : -prc_pkg::PI_Q20;
            end else begin
                r_b_x <= x0;
                r_b_y <= y0;
                r_b_z <= 32'sd0;
            end
        end
    end

    // CORDIC chain
    logic               c_valid [0:CORDIC_STEPS];
    logic signed [63:0] c_x     [0:CORDIC_STEPS];
    logic signed [63:0] c_y     [0:CORDIC_STEPS];
    logic signed [31:0] c_z     [0:CORDIC_STEPS];
    prc_pkg::t_side     c_side  [0:CORDIC_STEPS];

    assign c_valid[0] = r_b_valid;
    assign c_x[0]     = r_b_x;
    assign c_y[0]     = r_b_y;
    assign c_z[0]     = r_b_z;
    assign c_side[0]  = r_b_side;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        prc_cordic_stage #(.STEP(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    prc_pkg::t_side     cs;
    logic signed [63:0] cxn;
    logic signed [31:0] zf, zw;
    assign cs  = c_side[CORDIC_STEPS];
    assign cxn = c_x[CORDIC_STEPS];

    always_comb begin
        zf = cs.zero ? 32'sd0 : c_z[CORDIC_STEPS];
        if (zf < 32'(r_tmin))      zw = zf + prc_pkg::TWO_PI_Q20;
        else if (zf > 32'(r_tmax)) zw = zf - prc_pkg::TWO_PI_Q20;
        else                       zw = zf;
    end

    // products for the epipole-at-infinity mode, result at stage E
    logic signed [95:0] p_cxpx, p_cypy, p_cxpy, p_cypx;
    prc_mul48 u_mul_cxpx (.i_clk(i_clk), .i_en(en), .i_a(r_cx), .i_b(cs.px), .o_p(p_cxpx));
    prc_mul48 u_mul_cypy (.i_clk(i_clk), .i_en(en), .i_a(r_cy), .i_b(cs.py), .o_p(p_cypy));
    prc_mul48 u_mul_cxpy (.i_clk(i_clk), .i_en(en), .i_a(r_cx), .i_b(cs.py), .o_p(p_cxpy));
    prc_mul48 u_mul_cypx (.i_clk(i_clk), .i_en(en), .i_a(r_cy), .i_b(cs.px), .o_p(p_cypx));

    // stage D: gain products, angle wrap
    logic               r_d_valid, r_d_zero;
    logic [61:0]        r_d_hik, r_d_lok;
    logic signed [31:0] r_d_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_valid <= 1'b0;
        else if (en)  r_d_valid <= c_valid[CORDIC_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_zero <= cs.zero;
            r_d_hik  <= cxn[63:32] * prc_pkg::KINV_Q30;
            r_d_lok  <= cxn[31:0] * prc_pkg::KINV_Q30;
            r_d_d    <= zw - 32'(r_tmin);
        end
    end

    // stage E: magnitude, angle times radius_max partials
    logic [65:0]        gsum;
    logic               r_e_valid;
    logic [55:0]        r_e_mag;
    logic signed [56:0] r_e_plo;
    logic signed [55:0] r_e_phi;

    assign gsum = (66'(r_d_hik) << 2) + 66'((64'(r_d_lok) + 64'd536870912) >> 30)
                  + 66'd2048;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_valid <= 1'b0;
        else if (en)  r_e_valid <= r_d_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_mag <= r_d_zero ? 56'd0 : {2'b00, gsum[65:12]};
            r_e_plo <= r_d_d * $signed({1'b0, r_rmax[23:0]});
            r_e_phi <= r_d_d * $signed({1'b0, r_rmax[46:24]});
        end
    end

    // stage F: rounding and mode select
    logic signed [89:0] th_fin;
    logic signed [99:0] rho_inf, th_inf;
    logic               r_f_valid;
    logic signed [89:0] r_f_rho, r_f_th;

    assign th_fin = ((90'(r_e_phi) <<< 24) + 90'(r_e_plo) + 90'sd524288) >>> 20;
    assign rho_inf = (100'(p_cxpx) + 100'(p_cypy) + 100'sd32768) >>> 16;
    assign th_inf  = (100'(p_cxpy) - 100'(p_cypx) - (100'(r_tmin) <<< 12)
                      + 100'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_valid <= 1'b0;
        else if (en)  r_f_valid <= r_e_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_mode[0]) begin
                r_f_rho <= rho_inf[89:0];
                r_f_th  <= th_inf[89:0];
            end else begin
                r_f_rho <= $signed({34'd0, r_e_mag});
                r_f_th  <= th_fin;
            end
        end
    end

    // stage G: offset, mirror, saturate
    logic signed [89:0] rho2, wm, hm, rho_o, th_o;
    logic signed [47:0] r_out_x, r_out_y;

    assign rho2 = r_f_rho - 90'(r_rmin);
    assign wm   = 90'($signed({2'b00, r_size[15:0]}) - 18'sd1) <<< 16;
    assign hm   = 90'($signed({2'b00, r_size[31:16]}) - 18'sd1) <<< 16;
    assign rho_o = r_mode[1] ? (wm - rho2) : rho2;
    assign th_o  = r_mode[1] ? (hm - r_f_th) : r_f_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (en)  r_out_valid <= r_f_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x <= sat48(rho_o);
            r_out_y <= sat48(th_o);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rect.rect_x = r_out_x;
    assign o_rect.rect_y = r_out_y;

endmodule

@@ rtl/prc_check.sv @@
// Port-level checks for polar_rectify_point_map, bound to the top level.
// Depends on prc_pkg.
module prc_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input prc_pkg::t_point_out o_rect
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_rect))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind polar_rectify_point_map prc_check u_prc_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rect  (o_rect)
);

@@ test/testbench.sv @@
// Self-checking testbench for polar_rectify_point_map: predicts each rectified point
// and compares it with the block output. Depends on rtl/prc_pkg.sv and the RTL top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      LATENCY   = prc_pkg::CORDIC_STEPS_DEF + 6;
    localparam int      NUM_RAND  = 450;
    localparam longint  CYCLE_CAP = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    prc_pkg::t_point_in  i_point = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    prc_pkg::t_point_out o_rect;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_idx = 3'd0;
    logic [47:0]         i_cfg_data = '0;

    polar_rectify_point_map dut (.*);

    // Scoreboard: own copy of the registers and the map, queue of expected points
    class rect_scoreboard;
        logic signed [47:0]  cen_x, cen_y, rmin;
        logic [1:0]          flags;
        logic [46:0]         rmax;
        logic signed [24:0]  ang_lo, ang_hi;
        logic [31:0]         size_wh;
        prc_pkg::t_point_out expected_q[$];
        int                  errors;
        int                  checked;

        function new();
            cen_x = '0; cen_y = '0; rmin = '0; flags = '0; rmax = '0;
            ang_lo = '0; ang_hi = '0; size_wh = '0; errors = 0; checked = 0;
        endfunction

        function void set_reg(prc_pkg::t_reg_idx idx, logic [47:0] d);
            case (idx)
                prc_pkg::REG_CENTER_X:   cen_x = d;
                prc_pkg::REG_CENTER_Y:   cen_y = d;
                prc_pkg::REG_MODE_FLAGS: flags = d[1:0];
                prc_pkg::REG_RHO_MIN:    rmin = d;
                prc_pkg::REG_RADIUS_MAX: rmax = d[46:0];
                prc_pkg::REG_THETA_MIN:  ang_lo = d[24:0];
                prc_pkg::REG_THETA_MAX:  ang_hi = d[24:0];
                prc_pkg::REG_OUT_SIZE:   size_wh = d[31:0];
                default: ;
            endcase
        endfunction

        static function logic signed [127:0] round_shift(logic signed [127:0] a, int s);
            logic signed [127:0] half;
            half = 128'sd1 <<< (s - 1);
            return (a + half) >>> s;
        endfunction

        static function logic signed [47:0] clamp48(logic signed [127:0] a);
            if (a > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
            if (a < -128'sh8000_0000_0000) return 48'sh8000_0000_0000;
            return a[47:0];
        endfunction

        static function longint step_angle(int i);
            case (i)
                0: return 823550;
                1: return 486170;
                2: return 256879;
                3: return 130396;
                4: return 65451;
                5: return 32757;
                6: return 16383;
                7: return 8192;
                default: return (i <= 20) ? (64'sd1 <<< (20 - i)) : 0;
            endcase
        endfunction

        function void note_point(prc_pkg::t_point_in p);
            logic signed [127:0] px, py, cx, cy, rho, th, tmin, tmax;
            logic [127:0]        ux, gain;
            longint              x, y, z, xs, ys, w, h;
            prc_pkg::t_point_out e;
            px = p.point_x; py = p.point_y; cx = cen_x; cy = cen_y;
            tmin = ang_lo; tmax = ang_hi;
            if (flags[0]) begin
                rho = round_shift(cx * px + cy * py, 16);
                th = round_shift(cx * py - cy * px - tmin * 4096, 16);
            end else begin
                x = (px - cx) * 4096;
                y = (py - cy) * 4096;
                z = 0;
                ux = 0;
                if (x != 0 || y != 0) begin
                    if (x < 0) begin
                        z = (y >= 0) ? prc_pkg::PI_Q20 : -prc_pkg::PI_Q20;
                        x = -x;
                        y = -y;
                    end
                    for (int i = 0; i < prc_pkg::CORDIC_STEPS_DEF; i++) begin
                        xs = x >>> i;
                        ys = y >>> i;
                        if (y > 0) begin
                            x += ys; y -= xs; z += step_angle(i);
                        end else begin
                            x -= ys; y += xs; z -= step_angle(i);
                        end
                    end
                    ux = x;
                    gain = (ux >> 32) * prc_pkg::KINV_Q30 * 4
                         + (((ux & 128'hFFFF_FFFF) * prc_pkg::KINV_Q30
                             + (128'd1 << 29)) >> 30);
                    ux = (gain + 2048) >> 12;
                end
                rho = $signed(ux);
                if (z < tmin) z += prc_pkg::TWO_PI_Q20;
                else if (z > tmax) z -= prc_pkg::TWO_PI_Q20;
                th = round_shift((z - tmin) * $signed({81'd0, rmax}), 20);
            end
            rho = rho - rmin;
            if (flags[1]) begin
                w = size_wh[15:0];
                h = size_wh[31:16];
                rho = (w - 1) * 65536 - rho;
                th = (h - 1) * 65536 - th;
            end
            e.rect_x = clamp48(rho);
            e.rect_y = clamp48(th);
            expected_q.push_back(e);
        endfunction

        task report(string what, logic [47:0] got, logic [47:0] want);
            errors++;
            $display("MISMATCH %s: got %h expected %h", what, got, want);
        endtask

        task check_rect(prc_pkg::t_point_out r);
            prc_pkg::t_point_out e;
            if (expected_q.size() == 0) begin
                report("unexpected transfer", r.rect_x, 48'd0);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (r.rect_x !== e.rect_x) report("rect_x", r.rect_x, e.rect_x);
            if (r.rect_y !== e.rect_y) report("rect_y", r.rect_y, e.rect_y);
        endtask
    endclass

    rect_scoreboard sb = new();
    bit     quiet = 0;     // no idling on either side
    bit     hold_req = 0;  // ask the receiver for a long hold-off
    longint cycles = 0;
    int     sent = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("polar_rectify_point_map verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_rect(o_rect);
    end

    // receiver side: random stall bursts plus one long hold-off
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
                hold_req = 0;
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 9);
                i_stall <= (!quiet && $urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(prc_pkg::t_reg_idx idx, logic [47:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    // stop offering and wait until every accepted point has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_all(logic [47:0] cx, logic [47:0] cy, logic [1:0] fl,
                           logic [47:0] rmin, logic [46:0] rmax, logic [24:0] tlo,
                           logic [24:0] thi, logic [31:0] sz);
        drain();
        write_reg(prc_pkg::REG_CENTER_X, cx);
        write_reg(prc_pkg::REG_CENTER_Y, cy);
        write_reg(prc_pkg::REG_MODE_FLAGS, {46'd0, fl});
        write_reg(prc_pkg::REG_RHO_MIN, rmin);
        write_reg(prc_pkg::REG_RADIUS_MAX, {1'b0, rmax});
        write_reg(prc_pkg::REG_THETA_MIN, {{23{tlo[24]}}, tlo});
        write_reg(prc_pkg::REG_THETA_MAX, {{23{thi[24]}}, thi});
        write_reg(prc_pkg::REG_OUT_SIZE, {16'd0, sz});
    endtask

    task automatic send_point(logic [47:0] x, logic [47:0] y);
        prc_pkg::t_point_in p;
        int gap;
        p.point_x = x;
        p.point_y = y;
        i_valid <= 1'b1;
        i_point <= p;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(p);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // mostly points near the centre, some anywhere in the field
    task automatic send_random();
        logic signed [47:0] dx, dy;
        if ($urandom_range(0, 2) == 0) begin
            send_point(rand48(), rand48());
        end else begin
            dx = $signed(48'($urandom_range(0, 2 ** 26))) - 48'sd33554432;
            dy = $signed(48'($urandom_range(0, 2 ** 26))) - 48'sd33554432;
            send_point(sb.cen_x + dx, sb.cen_y + dy);
        end
    endtask

    localparam logic [47:0] P_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] P_MIN = 48'h8000_0000_0000;
    localparam logic [24:0] A_PI  = 25'd3294199;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full circle, identity-like scaling
        set_all(48'd0, 48'd0, 2'd0, 48'd0, 47'd65536, -A_PI, A_PI, {16'd480, 16'd640});
        send_point(48'd0, 48'd0);
        send_point(-48'sd65536, 48'd0);
        send_point(48'd65536, 48'd0);
        send_point(48'd0, 48'd65536);
        send_point(48'd0, -48'sd65536);
        send_point(-48'sd65536, -48'sd1);
        send_point(P_MAX, P_MAX);
        send_point(P_MIN, P_MIN);
        send_point(P_MIN, 48'd0);
        send_point(P_MAX, P_MIN);
        send_point(P_MIN, P_MAX);
        send_point(48'd1, 48'd0);
        // empty interval, mirror with zero size, extreme scaling
        set_all(48'd0, 48'd0, 2'd2, P_MAX, 47'h7FFF_FFFF_FFFF, 25'd0, 25'd0, 32'd0);
        send_point(48'd0, 48'd0);
        send_point(-48'sd65536, 48'd0);
        send_point(48'd0, -48'sd65536);
        send_point(P_MAX, 48'd3);
        // epipole at infinity, unit direction
        set_all(48'd65536, 48'd0, 2'd1, 48'd0, 47'd0, 25'h100_0000, 25'd0, 32'd0);
        send_point(48'd0, 48'd0);
        send_point(P_MAX, P_MAX);
        send_point(P_MIN, P_MIN);
        send_point(48'd12345678, -48'sd987654);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_all(48'd0, 48'd0, 2'd0, 48'd0, 47'd65536, -A_PI, A_PI,
                           {16'd480, 16'd640});
                1: set_all(rand48(), rand48(), 2'd3, P_MIN, 47'h7FFF_FFFF_FFFF,
                           25'h100_0000, 25'h0FF_FFFF, 32'hFFFF_FFFF);
                2: set_all(48'd46341, 48'd46341, 2'd1, rand48(), 47'(rand48()),
                           25'($urandom), 25'($urandom), $urandom);
                3: set_all(rand48(), rand48(), 2'd2, rand48(), 47'($urandom),
                           A_PI, -A_PI, $urandom);
                4: set_all(rand48(), rand48(), 2'($urandom), rand48(), 47'(rand48()),
                           25'($urandom), 25'($urandom), $urandom);
                default: set_all(48'd5 << 16, -48'sd3 << 16, 2'd0, 48'd100,
                                 47'd1 << 20, 25'h100_0000, 25'h0FF_FFFF,
                                 {16'd1, 16'd1});
            endcase
            for (int k = 0; k < NUM_RAND / 6; k++) begin
                if (ph == 0 && k == 10) hold_req = 1;
                if (ph == 5 && k == 40) quiet = 1;
                send_random();
            end
        end
        i_valid <= 1'b0;
        drain();

        $display("Checked %0d rectified points from %0d inputs over several register",
                 sb.checked, sent);
        $display("settings: finite and infinite epipole, mirror, wrap and saturation.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("polar_rectify_point_map verification clean");
        end else begin
            $display("polar_rectify_point_map verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/prc_pkg.sv
rtl/prc_cordic_stage.sv
rtl/prc_mul48.sv
rtl/polar_rectify_point_map.sv
rtl/prc_check.sv
test/testbench.sv
